### rtl/core/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// Shared constants, codes and types of the box versus frustum classifier.
// ----------------------------------------------------------------------------
package afc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_WIDTH_DEF = 32;

  localparam int TABLE_DEPTH = 80;
  localparam int IDX_W       = 7;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam int SET_FRUSTUM  = 0;
  localparam int SET_ABS_FRU  = 1;
  localparam int SET_NEARFAR  = 2;
  localparam int SET_SCISSOR  = 3;
  localparam int SET_ABS_SCI  = 4;

  localparam logic [0:0] REG_BYPASS = 1'b0;
  localparam logic [0:0] REG_FAR    = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  localparam logic [1:0] OUT_OUTSIDE = 2'd0;
  localparam logic [1:0] OUT_INSIDE  = 2'd1;
  localparam logic [1:0] OUT_SCISSOR = 2'd2;

  typedef struct packed {
    logic outside;
    logic side;
    logic scissor;
  } afc_flags_t;

  function automatic int cidx(input int set, input int row, input int col);
    return set * 16 + row * 4 + col;
  endfunction

endpackage

### rtl/core/afc_table.sv
// ----------------------------------------------------------------------------
// afc_table
// Plane coefficient register file: one write port, every entry read in place.
// ----------------------------------------------------------------------------
module afc_table #(
  parameter int NUM_WIDTH = afc_pkg::NUM_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [afc_pkg::IDX_W-1:0]   waddr,
  input  logic signed [NUM_WIDTH-1:0] wdata,
  output logic signed [NUM_WIDTH-1:0] coef [afc_pkg::TABLE_DEPTH]
);

  logic signed [NUM_WIDTH-1:0] mem [afc_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we && (int'(waddr) < afc_pkg::TABLE_DEPTH)) begin
      mem[waddr] <= wdata;
    end
  end

  assign coef = mem;

endmodule

### rtl/core/afc_prod.sv
// ----------------------------------------------------------------------------
// afc_prod
// Product stage: all plane products of center and extents, plus offsets.
// ----------------------------------------------------------------------------
module afc_prod #(
  parameter int NUM_WIDTH = afc_pkg::NUM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [NUM_WIDTH-1:0]   c    [3],
  input  logic signed [NUM_WIDTH-1:0]   e    [3],
  input  logic signed [NUM_WIDTH-1:0]   adj,
  input  logic signed [NUM_WIDTH-1:0]   coef [afc_pkg::TABLE_DEPTH],
  output logic signed [2*NUM_WIDTH-1:0] dp   [6][3],
  output logic signed [2*NUM_WIDTH-1:0] rp   [6][3],
  output logic signed [NUM_WIDTH:0]     doff [6],
  output logic signed [2*NUM_WIDTH-1:0] sdp  [4][3],
  output logic signed [2*NUM_WIDTH-1:0] srp  [4][3],
  output logic signed [NUM_WIDTH:0]     soff [4]
);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 4; p++) begin
        for (int r = 0; r < 3; r++) begin
          dp[p][r]  <= c[r] * coef[afc_pkg::cidx(afc_pkg::SET_FRUSTUM, r, p)];
          rp[p][r]  <= e[r] * coef[afc_pkg::cidx(afc_pkg::SET_ABS_FRU, r, p)];
          sdp[p][r] <= c[r] * coef[afc_pkg::cidx(afc_pkg::SET_SCISSOR, r, p)];
          srp[p][r] <= e[r] * coef[afc_pkg::cidx(afc_pkg::SET_ABS_SCI, r, p)];
        end
        doff[p] <= (NUM_WIDTH+1)'(coef[afc_pkg::cidx(afc_pkg::SET_FRUSTUM, 3, p)]);
        soff[p] <= (NUM_WIDTH+1)'(coef[afc_pkg::cidx(afc_pkg::SET_SCISSOR, 3, p)]);
      end
      for (int q = 0; q < 2; q++) begin
        for (int r = 0; r < 3; r++) begin
          dp[4+q][r] <= c[r] * coef[afc_pkg::cidx(afc_pkg::SET_NEARFAR, r, q)];
          rp[4+q][r] <= e[r] * coef[afc_pkg::cidx(afc_pkg::SET_NEARFAR, r, q+2)];
        end
      end
      doff[4] <= (NUM_WIDTH+1)'(coef[afc_pkg::cidx(afc_pkg::SET_NEARFAR, 3, 0)])
               + (NUM_WIDTH+1)'(adj);
      doff[5] <= (NUM_WIDTH+1)'(coef[afc_pkg::cidx(afc_pkg::SET_NEARFAR, 3, 1)]);
    end
  end

endmodule

### rtl/core/afc_eval.sv
// ----------------------------------------------------------------------------
// afc_eval
// Sum stage (distances and radii) followed by the sign test stage.
// ----------------------------------------------------------------------------
module afc_eval #(
  parameter int FRAC_BITS = afc_pkg::FRAC_BITS_DEF,
  parameter int NUM_WIDTH = afc_pkg::NUM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en_sum,
  input  logic                          en_flag,
  input  logic signed [2*NUM_WIDTH-1:0] dp   [6][3],
  input  logic signed [2*NUM_WIDTH-1:0] rp   [6][3],
  input  logic signed [NUM_WIDTH:0]     doff [6],
  input  logic signed [2*NUM_WIDTH-1:0] sdp  [4][3],
  input  logic signed [2*NUM_WIDTH-1:0] srp  [4][3],
  input  logic signed [NUM_WIDTH:0]     soff [4],
  output afc_pkg::afc_flags_t           flags
);

  localparam int AW = 2*NUM_WIDTH + FRAC_BITS + 4;

  logic signed [AW-1:0] dsum  [6];
  logic signed [AW-1:0] rad   [6];
  logic signed [AW-1:0] sdist [4];
  logic signed [AW-1:0] srad  [4];
  logic signed [AW-1:0] tot   [6];
  logic signed [AW-1:0] sd    [4];
  logic signed [AW-1:0] ss    [4];
  afc_pkg::afc_flags_t  flags_next;

  always_ff @(posedge clk) begin
    if (en_sum) begin
      for (int p = 0; p < 6; p++) begin
        dsum[p] <= AW'(dp[p][0]) + AW'(dp[p][1]) + AW'(dp[p][2])
                 + (AW'(doff[p]) <<< FRAC_BITS);
        rad[p]  <= AW'(rp[p][0]) + AW'(rp[p][1]) + AW'(rp[p][2]);
      end
      for (int p = 0; p < 4; p++) begin
        sdist[p] <= AW'(sdp[p][0]) + AW'(sdp[p][1]) + AW'(sdp[p][2])
                  + (AW'(soff[p]) <<< FRAC_BITS);
        srad[p]  <= AW'(srp[p][0]) + AW'(srp[p][1]) + AW'(srp[p][2]);
      end
    end
  end

  always_comb begin
    flags_next = '0;
    for (int p = 0; p < 6; p++) begin
      tot[p] = dsum[p] + rad[p];
      if (tot[p][AW-1]) begin
        flags_next.outside = 1'b1;
      end
    end
    for (int p = 0; p < 4; p++) begin
      sd[p] = rad[p] - dsum[p];
      ss[p] = srad[p] - sdist[p];
      if (!sd[p][AW-1] && (sd[p] != '0)) begin
        flags_next.side = 1'b1;
      end
      if (!ss[p][AW-1] && (ss[p] != '0)) begin
        flags_next.scissor = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_flag) begin
      flags <= flags_next;
    end
  end

endmodule

### rtl/core/aabb_frustum_cull_with_scissor.sv
// ----------------------------------------------------------------------------
// aabb_frustum_cull_with_scissor
// Classifies a center/half-extent box against frustum and scissor planes.
// ----------------------------------------------------------------------------
// One item per cycle while in_ready is high. A load beat (op 0) writes the
// coefficient table at the accepting edge and produces no result. A test
// beat (op 1) runs through five register stages (input capture, products,
// sums, sign tests, output); an output stall holds each valid stage with no
// bubble ahead. The product stage reads the table as it takes the test, before
// a later beat is taken, so a load may directly follow or precede a test.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_with_scissor #(
  parameter int FRAC_BITS = afc_pkg::FRAC_BITS_DEF,
  parameter int NUM_WIDTH = afc_pkg::NUM_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [afc_pkg::ADDR_W-1:0]       paddr,
  input  logic [afc_pkg::DATA_W-1:0]       pwdata,
  output logic [afc_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             op,
  input  logic [afc_pkg::IDX_W-1:0]        coef_index,
  input  logic signed [NUM_WIDTH-1:0]      coef_value,
  input  logic signed [NUM_WIDTH-1:0]      center_x,
  input  logic signed [NUM_WIDTH-1:0]      center_y,
  input  logic signed [NUM_WIDTH-1:0]      center_z,
  input  logic signed [NUM_WIDTH-1:0]      extent_x,
  input  logic signed [NUM_WIDTH-1:0]      extent_y,
  input  logic signed [NUM_WIDTH-1:0]      extent_z,
  input  logic [NUM_WIDTH-2:0]             far_override,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       outcome
);

  logic                        bypass_active;
  logic [NUM_WIDTH-2:0]        default_far_clip;
  logic                        cfg_we;

  logic                        v1, v2, v3, v4;
  logic                        b1, b2, b3, b4;
  logic                        rdy1, rdy2, rdy3, rdy4, rdyo;
  logic                        acc_in, acc_test;

  logic signed [NUM_WIDTH-1:0] c1 [3];
  logic signed [NUM_WIDTH-1:0] e1 [3];
  logic signed [NUM_WIDTH-1:0] adj1;
  logic signed [NUM_WIDTH-1:0] adj_next;

  logic signed [NUM_WIDTH-1:0]   coef [afc_pkg::TABLE_DEPTH];
  logic signed [2*NUM_WIDTH-1:0] dp   [6][3];
  logic signed [2*NUM_WIDTH-1:0] rp   [6][3];
  logic signed [NUM_WIDTH:0]     doff [6];
  logic signed [2*NUM_WIDTH-1:0] sdp  [4][3];
  logic signed [2*NUM_WIDTH-1:0] srp  [4][3];
  logic signed [NUM_WIDTH:0]     soff [4];
  afc_pkg::afc_flags_t           flags;
  logic [1:0]                    outcome_next;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass_active    <= 1'b0;
      default_far_clip <= '0;
    end else if (cfg_we) begin
      case (paddr[2])
        afc_pkg::REG_BYPASS: bypass_active    <= pwdata[0];
        afc_pkg::REG_FAR:    default_far_clip <= pwdata[NUM_WIDTH-2:0];
        default:             bypass_active    <= bypass_active;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      afc_pkg::REG_BYPASS: prdata = afc_pkg::DATA_W'(bypass_active);
      afc_pkg::REG_FAR:    prdata = afc_pkg::DATA_W'(default_far_clip);
      default:             prdata = '0;
    endcase
  end

  // pipeline control
  assign rdyo     = !out_valid || out_ready;
  assign rdy4     = !v4 || rdyo;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign acc_in   = in_valid && in_ready;
  assign acc_test = acc_in && (op == afc_pkg::OP_TEST);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= acc_test;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdyo) out_valid <= v4;
    end
  end

  always_comb begin
    adj_next = '0;
    if (far_override != '0) begin
      adj_next = $signed({1'b0, far_override}) - $signed({1'b0, default_far_clip});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      c1[0] <= center_x;
      c1[1] <= center_y;
      c1[2] <= center_z;
      e1[0] <= extent_x;
      e1[1] <= extent_y;
      e1[2] <= extent_z;
      adj1  <= adj_next;
      b1    <= bypass_active;
    end
    if (rdy2) b2 <= b1;
    if (rdy3) b3 <= b2;
    if (rdy4) b4 <= b3;
  end

  afc_table #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_table (
    .clk   (clk),
    .we    (acc_in && (op == afc_pkg::OP_LOAD)),
    .waddr (coef_index),
    .wdata (coef_value),
    .coef  (coef)
  );

  afc_prod #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_prod (
    .clk  (clk),
    .en   (rdy2),
    .c    (c1),
    .e    (e1),
    .adj  (adj1),
    .coef (coef),
    .dp   (dp),
    .rp   (rp),
    .doff (doff),
    .sdp  (sdp),
    .srp  (srp),
    .soff (soff)
  );

  afc_eval #(
    .FRAC_BITS (FRAC_BITS),
    .NUM_WIDTH (NUM_WIDTH)
  ) u_eval (
    .clk     (clk),
    .en_sum  (rdy3),
    .en_flag (rdy4),
    .dp      (dp),
    .rp      (rp),
    .doff    (doff),
    .sdp     (sdp),
    .srp     (srp),
    .soff    (soff),
    .flags   (flags)
  );

  always_comb begin
    if (b4) begin
      outcome_next = afc_pkg::OUT_INSIDE;
    end else if (flags.outside) begin
      outcome_next = afc_pkg::OUT_OUTSIDE;
    end else if (flags.side && flags.scissor) begin
      outcome_next = afc_pkg::OUT_SCISSOR;
    end else begin
      outcome_next = afc_pkg::OUT_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rdyo) begin
      outcome <= outcome_next;
    end
  end

endmodule
